FILE: hw/rtl/fixed_block_pool_allocator_defines.svh
// assertion helpers shared by the allocator rtl
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH

// checked only outside reset
`define FBPA_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define FBPA_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: hw/rtl/fbpa_pkg.sv
package fbpa_pkg;

  localparam int unsigned MaxBlocksDef = 64;

  localparam int unsigned AddrW   = 32;
  localparam int unsigned BsizeW  = 16;
  localparam int unsigned NblkW   = 7;
  localparam int unsigned IdxOutW = 6;
  localparam int unsigned UsedW   = 7;
  localparam int unsigned StatW   = 2;
  localparam int unsigned PaddrW  = 4;
  localparam int unsigned PdataW  = 32;

  // result tdata: index, address, used count, then zero fill to whole bytes
  localparam int unsigned OutFieldsW = IdxOutW + AddrW + UsedW;
  localparam int unsigned OutTdataW  = ((OutFieldsW + 7) / 8) * 8;
  localparam int unsigned OutPadW    = OutTdataW - OutFieldsW;

  // register word index, taken from paddr[3:2]
  localparam logic [1:0] RegBase  = 2'd0;
  localparam logic [1:0] RegBsize = 2'd1;
  localparam logic [1:0] RegNblk  = 2'd2;

  localparam logic [BsizeW-1:0] BsizeReset = 16'd64;
  localparam logic [NblkW-1:0]  NblkReset  = 7'd64;

  localparam logic ReqAlloc = 1'b0;
  localparam logic ReqFree  = 1'b1;

  typedef enum logic [StatW-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2,
    ST_NULL    = 2'd3
  } status_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: hw/rtl/fbpa_div.sv
module fbpa_div import fbpa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [AddrW-1:0]  dividend_i,
  input  logic [BsizeW-1:0] divisor_i,
  output logic [AddrW-1:0]  quotient_o,
  output div_stat_t         status_o
);

  localparam int unsigned CntW = $clog2(AddrW);

  logic [BsizeW-1:0] rem_q, rem_d;
  logic [AddrW-1:0]  quo_q, quo_d;
  logic [BsizeW-1:0] dsr_q, dsr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  logic [BsizeW:0]   shifted;
  logic [BsizeW+1:0] trial;
  logic              ge;

  // one quotient bit per cycle, restoring form; a zero divisor yields all ones
  assign shifted = {rem_q, quo_q[AddrW-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dsr_q};
  assign ge      = ~trial[BsizeW+1];

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? trial[BsizeW-1:0] : shifted[BsizeW-1:0];
      quo_d = {quo_q[AddrW-2:0], ge};
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(AddrW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign quotient_o    = quo_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

FILE: hw/rtl/fixed_block_pool_allocator.sv
// Fixed-size block pool allocator.
// Request items come in on the s_axis channel: tuser selects allocate or free,
// tdata carries the address to free. Each request gives exactly one result
// item on m_axis with a status code in tuser and the block index, block
// address and used block count in tdata.
// Allocate walks the allocation map one block per cycle from index zero and
// settles on the first free block, or finds the pool full once it passes the
// block count. A free of a nonzero address runs the 32-step divider for
// (address - base) / block size; a free of address zero skips the divider.
// One request is worked on at a time; s_axis_tready is high while the
// sequencer is idle, also while the last result still waits on m_axis.
// A stalled receiver holds the result register, and a finished request then
// waits until that register is taken before the block turns idle again.
// Reset marks every block free, clears the used count and sets block size 64,
// block count 64 and base 0. Registers are to be written over the APB port only
// while the block is idle; the block itself does not enforce this.
`include "fixed_block_pool_allocator_defines.svh"

module fixed_block_pool_allocator import fbpa_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = MaxBlocksDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // apb register port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PaddrW-1:0]    paddr,
  input  logic [PdataW-1:0]    pwdata,
  output logic [PdataW-1:0]    prdata,
  output logic                 pready,
  // request items
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [AddrW-1:0]     s_axis_tdata,  // [31:0] free_address
  input  logic                 s_axis_tuser,  // [0] req_type
  // result items
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutTdataW-1:0] m_axis_tdata,  // [5:0] block_index, [37:6] block_address,
                                               // [44:38] used_count, [47:45] zero
  output logic [StatW-1:0]     m_axis_tuser   // [1:0] status
);

  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  state_e                 state_q, state_d;
  logic [AddrW-1:0]       base_q, base_d;
  logic [BsizeW-1:0]      bsize_q, bsize_d;
  logic [NblkW-1:0]       nblk_q, nblk_d;
  logic [MAX_BLOCKS-1:0]  map_q, map_d;
  logic [CW-1:0]          used_q, used_d;
  logic [CW-1:0]          idx_q, idx_d;
  logic [AddrW-1:0]       acc_q, acc_d;
  status_e                res_stat_q, res_stat_d;
  logic [IdxOutW-1:0]     res_idx_q, res_idx_d;
  logic [AddrW-1:0]       res_addr_q, res_addr_d;
  logic                   m_tvalid_q, m_tvalid_d;
  logic [OutTdataW-1:0]   m_tdata_q, m_tdata_d;
  logic [StatW-1:0]       m_tuser_q, m_tuser_d;

  logic                   in_acc;
  logic                   cfg_wr;
  logic [CW-1:0]          cnt_eff;
  logic                   div_start;
  logic [AddrW-1:0]       div_quo;
  div_stat_t              div_st;
  logic                   free_hit;

  fbpa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (s_axis_tdata - base_q),
    .divisor_i  (bsize_q),
    .quotient_o (div_quo),
    .status_o   (div_st)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign pready        = 1'b1;
  assign cfg_wr        = psel && penable && pwrite && pready;

  assign cnt_eff  = (32'(nblk_q) > 32'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(nblk_q);
  assign free_hit = (div_quo < 32'(cnt_eff)) && map_q[div_quo[IW-1:0]];

  always_comb begin
    case (paddr[3:2])
      RegBase:  prdata = base_q;
      RegBsize: prdata = PdataW'(bsize_q);
      RegNblk:  prdata = PdataW'(nblk_q);
      default:  prdata = '0;
    endcase
  end

  always_comb begin
    base_d  = base_q;
    bsize_d = bsize_q;
    nblk_d  = nblk_q;
    if (cfg_wr) begin
      case (paddr[3:2])
        RegBase:  base_d  = pwdata;
        RegBsize: bsize_d = pwdata[BsizeW-1:0];
        RegNblk:  nblk_d  = pwdata[NblkW-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    state_d    = state_q;
    map_d      = map_q;
    used_d     = used_q;
    idx_d      = idx_q;
    acc_d      = acc_q;
    res_stat_d = res_stat_q;
    res_idx_d  = res_idx_q;
    res_addr_d = res_addr_q;
    m_tvalid_d = m_tvalid_q && !m_axis_tready;
    m_tdata_d  = m_tdata_q;
    m_tuser_d  = m_tuser_q;
    div_start  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser == ReqAlloc) begin
            idx_d   = '0;
            acc_d   = base_q;
            state_d = S_SCAN;
          end else if (s_axis_tdata == '0) begin
            res_stat_d = ST_NULL;
            res_idx_d  = '0;
            res_addr_d = '0;
            state_d    = S_OUT;
          end else begin
            div_start = 1'b1;
            state_d   = S_DIV;
          end
        end
      end
      S_SCAN: begin
        if (idx_q >= cnt_eff) begin
          res_stat_d = ST_FULL;
          res_idx_d  = '0;
          res_addr_d = '0;
          state_d    = S_OUT;
        end else if (!map_q[idx_q[IW-1:0]]) begin
          map_d[idx_q[IW-1:0]] = 1'b1;
          used_d     = used_q + CW'(1);
          res_stat_d = ST_OK;
          res_idx_d  = IdxOutW'(idx_q);
          res_addr_d = acc_q;
          state_d    = S_OUT;
        end else begin
          // step to the next block and its address
          idx_d = idx_q + CW'(1);
          acc_d = acc_q + AddrW'(bsize_q);
        end
      end
      S_DIV: begin
        if (div_st.done) begin
          res_addr_d = '0;
          if (free_hit) begin
            map_d[div_quo[IW-1:0]] = 1'b0;
            if (used_q != '0) begin
              used_d = used_q - CW'(1);
            end
            res_stat_d = ST_OK;
            res_idx_d  = div_quo[IdxOutW-1:0];
          end else begin
            res_stat_d = ST_INVALID;
            res_idx_d  = '0;
          end
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!m_tvalid_q || m_axis_tready) begin
          m_tvalid_d = 1'b1;
          m_tdata_d  = {OutPadW'(0), UsedW'(used_q), res_addr_q, res_idx_q};
          m_tuser_d  = res_stat_q;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      base_q     <= '0;
      bsize_q    <= BsizeReset;
      nblk_q     <= NblkReset;
      map_q      <= '0;
      used_q     <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      base_q     <= base_d;
      bsize_q    <= bsize_d;
      nblk_q     <= nblk_d;
      map_q      <= map_d;
      used_q     <= used_d;
      m_tvalid_q <= m_tvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    acc_q      <= acc_d;
    res_stat_q <= res_stat_d;
    res_idx_q  <= res_idx_d;
    res_addr_q <= res_addr_d;
    m_tdata_q  <= m_tdata_d;
    m_tuser_q  <= m_tuser_d;
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tuser  = m_tuser_q;

  `FBPA_ASSERT(a_used_matches_map, used_q == CW'($countones(map_q)), "used count out of step with map")
  `FBPA_ASSERT(a_div_done_in_div, div_st.done |-> (state_q == S_DIV), "divider finished outside a free")
  `FBPA_ASSERT(a_scan_in_bounds, (state_q == S_SCAN) |-> (idx_q <= cnt_eff), "scan ran past block count")
  `FBPA_ASSERT(a_result_waits, ((state_q == S_OUT) && m_tvalid_q && !m_axis_tready) |=> (state_q == S_OUT), "result dropped while output stalled")

endmodule
